FILE: hw/rtl/spsm_pkg.sv
package spsm_pkg;

	// Page geometry
	localparam int PAGE_BYTES          = 4096;
	localparam int HEADER_BYTES        = 16;
	localparam int SLOT_ENTRY_BYTES    = 8;
	localparam int LENGTH_PREFIX_BYTES = 4;

	// Directory size and derived widths
	localparam int DIR_SLOTS  = (PAGE_BYTES - HEADER_BYTES) / SLOT_ENTRY_BYTES;
	localparam int DIR_AW     = $clog2(DIR_SLOTS);
	localparam int CNT_W      = $clog2(DIR_SLOTS + 1);
	localparam int PTR_W      = $clog2(PAGE_BYTES + 1);

	// Field widths
	localparam int OP_W   = 2;
	localparam int SLOT_W = 10;
	localparam int LEN_W  = 13;
	localparam int OFS_W  = 12;
	localparam int STAT_W = 2;

	// Space arithmetic width: covers row length plus prefix and entry
	localparam int NEED_W = ((LEN_W > PTR_W) ? LEN_W : PTR_W) + 1;
	// Slot compare width
	localparam int SCMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	// Deleted-flag store: words of flags plus one summary bit per word
	localparam int FLAG_W     = 32;
	localparam int BIT_W      = $clog2(FLAG_W);
	localparam int FLAG_WORDS = (DIR_SLOTS + FLAG_W - 1) / FLAG_W;
	localparam int FLAG_AW    = (FLAG_WORDS > 1) ? $clog2(FLAG_WORDS) : 1;

	// Directory entry: data offset over row length
	localparam int ENT_W = OFS_W + LEN_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_INIT   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_INVALID  = 2'd2,
		ST_DELETED  = 2'd3
	} status_t;

	// Flag store read request
	typedef struct packed {
		logic               rd;
		logic               search;
		logic [FLAG_AW-1:0] addr;
	} flg_req_t;

	// Flag store write-back
	typedef struct packed {
		logic               we;
		logic               clr;
		logic [FLAG_AW-1:0] addr;
		logic [FLAG_W-1:0]  data;
	} flg_wr_t;

	// Flag store read response
	typedef struct packed {
		logic               live;
		logic [FLAG_AW-1:0] word;
		logic [FLAG_W-1:0]  data;
	} flg_rsp_t;

	// Lowest set bit of a flag word
	function automatic logic [BIT_W-1:0] first_bit(input logic [FLAG_W-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = FLAG_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	// Lowest set bit of the summary vector
	function automatic logic [FLAG_AW-1:0] first_word(input logic [FLAG_WORDS-1:0] v);
		logic [FLAG_AW-1:0] idx;
		idx = '0;
		for (int i = FLAG_WORDS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = FLAG_AW'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: hw/rtl/spsm_ram.sv
module spsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/spsm_flags.sv
// Deleted-slot flags: one RAM word per 32 slots and a summary register with
// one bit per word. A clear summary bit means the whole word reads as zero,
// so page init only clears the summary.
module spsm_flags (
	input  logic              clk,
	input  logic              arst_n,
	input  spsm_pkg::flg_req_t req,
	input  spsm_pkg::flg_wr_t  wr,
	output spsm_pkg::flg_rsp_t rsp
);

	logic [spsm_pkg::FLAG_WORDS-1:0] summary_q;
	logic [spsm_pkg::FLAG_AW-1:0]    addr_sel;
	logic [spsm_pkg::FLAG_AW-1:0]    word_q;
	logic                            live_q;
	logic [spsm_pkg::FLAG_W-1:0]     ram_rdata;

	// Search picks the lowest word holding a deleted slot
	assign addr_sel = req.search ? spsm_pkg::first_word(summary_q) : req.addr;

	spsm_ram #(
		.WIDTH (spsm_pkg::FLAG_W),
		.DEPTH (spsm_pkg::FLAG_WORDS)
	) u_flag_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (req.rd),
		.raddr (addr_sel),
		.rdata (ram_rdata)
	);

	// Summary tracks which words hold any set flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q <= '0;
		end else if (wr.clr) begin
			summary_q <= '0;
		end else if (wr.we) begin
			summary_q[wr.addr] <= |wr.data;
		end
	end

	// Read-side tags, aligned with the RAM output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			word_q <= '0;
		end else if (req.rd) begin
			live_q <= summary_q[addr_sel];
			word_q <= addr_sel;
		end
	end

	assign rsp.live = live_q;
	assign rsp.word = word_q;
	assign rsp.data = live_q ? ram_rdata : '0;

endmodule

FILE: hw/rtl/slotted_page_slot_manager_top.sv
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   operation, slot_id, row_length
// result    out        out_valid / out_ready status, slot_no, data_offset, row_bytes
//
// Each request first reads the flag and entry memories, then decides and writes
// back; the registered memory reads set that split.
// A new request is taken while a result still waits; it then holds in the decide
// step until the output register frees.
// Reset leaves an empty page; the memories need no clearing pass.
module slotted_page_slot_manager_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [spsm_pkg::OP_W-1:0]   operation,
	input  logic [spsm_pkg::SLOT_W-1:0] slot_id,
	input  logic [spsm_pkg::LEN_W-1:0]  row_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [spsm_pkg::STAT_W-1:0] status,
	output logic [spsm_pkg::SLOT_W-1:0] slot_no,
	output logic [spsm_pkg::OFS_W-1:0]  data_offset,
	output logic [spsm_pkg::LEN_W-1:0]  row_bytes
);

	typedef enum logic {
		S_IDLE,
		S_LOOK
	} state_t;

	state_t state_q;

	// Latched request
	spsm_pkg::op_t              op_q;
	logic [spsm_pkg::SLOT_W-1:0] slot_q;
	logic [spsm_pkg::LEN_W-1:0]  len_q;

	// Page pointers
	logic [spsm_pkg::CNT_W-1:0] slot_count_q;
	logic [spsm_pkg::PTR_W-1:0] free_start_q;
	logic [spsm_pkg::PTR_W-1:0] free_end_q;

	// Output register
	logic                        out_valid_q;
	spsm_pkg::status_t           status_q;
	logic [spsm_pkg::SLOT_W-1:0] slot_no_q;
	logic [spsm_pkg::OFS_W-1:0]  data_offset_q;
	logic [spsm_pkg::LEN_W-1:0]  row_bytes_q;

	// Memory interfaces
	spsm_pkg::flg_req_t flg_req;
	spsm_pkg::flg_wr_t  flg_wr;
	spsm_pkg::flg_rsp_t flg_rsp;
	logic                         ent_we;
	logic [spsm_pkg::DIR_AW-1:0]  ent_waddr;
	logic [spsm_pkg::ENT_W-1:0]   ent_wdata;
	logic [spsm_pkg::ENT_W-1:0]   ent_rdata;

	logic accept;
	logic commit;

	// Decide-step values
	logic [spsm_pkg::PTR_W-1:0]  avail;
	logic [spsm_pkg::NEED_W-1:0] stored;
	logic [spsm_pkg::NEED_W-1:0] need;
	logic                        fits;
	logic [spsm_pkg::BIT_W-1:0]  free_bit;
	logic [spsm_pkg::BIT_W-1:0]  sid_bit;
	logic                        sid_valid;
	logic [spsm_pkg::PTR_W-1:0]  fe_new;
	logic [spsm_pkg::OFS_W-1:0]  ofs_new;
	logic [spsm_pkg::DIR_AW-1:0] reuse_slot;

	spsm_pkg::status_t           res_status;
	logic [spsm_pkg::SLOT_W-1:0] res_slot;
	logic [spsm_pkg::OFS_W-1:0]  res_ofs;
	logic [spsm_pkg::LEN_W-1:0]  res_len;
	logic [spsm_pkg::CNT_W-1:0]  nxt_count;
	logic [spsm_pkg::PTR_W-1:0]  nxt_fs;
	logic [spsm_pkg::PTR_W-1:0]  nxt_fe;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == S_LOOK) && (!out_valid_q || out_ready);

	// Read both memories as the request is taken
	always_comb begin
		flg_req.rd     = accept;
		flg_req.search = (spsm_pkg::op_t'(operation) == spsm_pkg::OP_INSERT);
		flg_req.addr   = slot_id[spsm_pkg::BIT_W +: spsm_pkg::FLAG_AW];
	end

	spsm_flags u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (flg_req),
		.wr     (flg_wr),
		.rsp    (flg_rsp)
	);

	spsm_ram #(
		.WIDTH (spsm_pkg::ENT_W),
		.DEPTH (spsm_pkg::DIR_SLOTS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (accept),
		.raddr (slot_id[spsm_pkg::DIR_AW-1:0]),
		.rdata (ent_rdata)
	);

	// Decide and build write-backs
	always_comb begin
		avail      = (free_end_q > free_start_q) ? (free_end_q - free_start_q) : '0;
		stored     = spsm_pkg::NEED_W'(len_q) + spsm_pkg::NEED_W'(spsm_pkg::LENGTH_PREFIX_BYTES);
		need       = stored + spsm_pkg::NEED_W'(spsm_pkg::SLOT_ENTRY_BYTES);
		fits       = spsm_pkg::NEED_W'(avail) >= need;
		free_bit   = spsm_pkg::first_bit(flg_rsp.data);
		sid_bit    = slot_q[spsm_pkg::BIT_W-1:0];
		sid_valid  = spsm_pkg::SCMP_W'(slot_q) < spsm_pkg::SCMP_W'(slot_count_q);
		fe_new     = free_end_q - spsm_pkg::PTR_W'(stored);
		ofs_new    = spsm_pkg::OFS_W'(fe_new + spsm_pkg::PTR_W'(spsm_pkg::LENGTH_PREFIX_BYTES));
		reuse_slot = spsm_pkg::DIR_AW'({flg_rsp.word, free_bit});

		res_status = spsm_pkg::ST_OK;
		res_slot   = slot_q;
		res_ofs    = '0;
		res_len    = '0;
		nxt_count  = slot_count_q;
		nxt_fs     = free_start_q;
		nxt_fe     = free_end_q;

		flg_wr.we   = 1'b0;
		flg_wr.clr  = 1'b0;
		flg_wr.addr = flg_rsp.word;
		flg_wr.data = flg_rsp.data;
		ent_we      = 1'b0;
		ent_waddr   = reuse_slot;
		ent_wdata   = {ofs_new, len_q};

		case (op_q)
			spsm_pkg::OP_INSERT: begin
				res_slot = '0;
				if (!fits) begin
					res_status = spsm_pkg::ST_NO_SPACE;
				end else if (flg_rsp.live) begin
					// Reuse lowest deleted slot
					res_slot    = spsm_pkg::SLOT_W'(reuse_slot);
					res_ofs     = ofs_new;
					res_len     = len_q;
					nxt_fe      = fe_new;
					flg_wr.we   = commit;
					flg_wr.data = flg_rsp.data & ~(spsm_pkg::FLAG_W'(1) << free_bit);
					ent_we      = commit;
				end else if (slot_count_q >= spsm_pkg::CNT_W'(spsm_pkg::DIR_SLOTS)) begin
					res_status = spsm_pkg::ST_NO_SPACE;
				end else begin
					// Append a new slot
					res_slot  = spsm_pkg::SLOT_W'(slot_count_q);
					res_ofs   = ofs_new;
					res_len   = len_q;
					nxt_fe    = fe_new;
					nxt_count = slot_count_q + spsm_pkg::CNT_W'(1);
					nxt_fs    = free_start_q + spsm_pkg::PTR_W'(spsm_pkg::SLOT_ENTRY_BYTES);
					ent_we    = commit;
					ent_waddr = slot_count_q[spsm_pkg::DIR_AW-1:0];
				end
			end
			spsm_pkg::OP_DELETE: begin
				if (!sid_valid) begin
					res_status = spsm_pkg::ST_INVALID;
				end else begin
					flg_wr.we   = commit;
					flg_wr.data = flg_rsp.data | (spsm_pkg::FLAG_W'(1) << sid_bit);
				end
			end
			spsm_pkg::OP_READ: begin
				if (!sid_valid) begin
					res_status = spsm_pkg::ST_INVALID;
				end else if (flg_rsp.data[sid_bit]) begin
					res_status = spsm_pkg::ST_DELETED;
				end else begin
					res_ofs = ent_rdata[spsm_pkg::ENT_W-1 -: spsm_pkg::OFS_W];
					res_len = ent_rdata[spsm_pkg::LEN_W-1:0];
				end
			end
			default: begin
				// Page init
				res_slot   = '0;
				nxt_count  = '0;
				nxt_fs     = spsm_pkg::PTR_W'(spsm_pkg::HEADER_BYTES);
				nxt_fe     = spsm_pkg::PTR_W'(spsm_pkg::PAGE_BYTES);
				flg_wr.clr = commit;
			end
		endcase
	end

	// Sequencer, page pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= spsm_pkg::OP_INIT;
			slot_q        <= '0;
			len_q         <= '0;
			slot_count_q  <= '0;
			free_start_q  <= spsm_pkg::PTR_W'(spsm_pkg::HEADER_BYTES);
			free_end_q    <= spsm_pkg::PTR_W'(spsm_pkg::PAGE_BYTES);
			out_valid_q   <= 1'b0;
			status_q      <= spsm_pkg::ST_OK;
			slot_no_q     <= '0;
			data_offset_q <= '0;
			row_bytes_q   <= '0;
		end else begin
			// A new result takes precedence over the one leaving
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= spsm_pkg::op_t'(operation);
						slot_q  <= slot_id;
						len_q   <= row_length;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (commit) begin
						slot_count_q  <= nxt_count;
						free_start_q  <= nxt_fs;
						free_end_q    <= nxt_fe;
						status_q      <= res_status;
						slot_no_q     <= res_slot;
						data_offset_q <= res_ofs;
						row_bytes_q   <= res_len;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_no     = slot_no_q;
	assign data_offset = data_offset_q;
	assign row_bytes   = row_bytes_q;

`ifndef NO_ASSERTIONS
	// Flag write-back never overlaps a flag read
	a_flag_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		!(flg_wr.we && flg_req.rd))
		else $error("flag read and write-back in the same cycle");

	// Directory never grows into row space
	a_free_order: assert property (@(posedge clk) disable iff (!arst_n)
		free_start_q <= free_end_q)
		else $error("free start passed free end");

	// Slot count stays within the directory
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_count_q <= spsm_pkg::CNT_W'(spsm_pkg::DIR_SLOTS))
		else $error("slot count beyond directory");

	// Entries are written only by a successful insert
	a_entry_write: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (op_q == spsm_pkg::OP_INSERT) && commit && fits)
		else $error("entry write outside insert");

	// A committed request returns to idle
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (state_q == S_IDLE) && out_valid_q)
		else $error("commit did not load result");
`endif

endmodule
